// ===== hw/rtl/md5tw_pkg.sv =====
package md5tw_pkg;

  // pipeline depth: one stage per md5 step
  localparam int MaxSteps   = 64;
  localparam int StageCount = MaxSteps;

  // fixed words of the final block
  localparam logic [31:0] PadWord = 32'h0000_0080;
  localparam logic [31:0] LenWord = 32'(72 * 8);

  // chaining value after reset (standard md5 initial value)
  localparam logic [31:0] InitA = 32'h6745_2301;
  localparam logic [31:0] InitB = 32'hEFCD_AB89;
  localparam logic [31:0] InitC = 32'h98BA_DCFE;
  localparam logic [31:0] InitD = 32'h1032_5476;
  localparam logic [6:0]  InitStepCount = 7'd64;
  localparam logic [3:0]  InitKeepBytes = 4'd6;

  // register indexes of the configuration port
  localparam logic [2:0] RegChainA    = 3'd0;
  localparam logic [2:0] RegChainB    = 3'd1;
  localparam logic [2:0] RegChainC    = 3'd2;
  localparam logic [2:0] RegChainD    = 3'd3;
  localparam logic [2:0] RegStepCount = 3'd4;
  localparam logic [2:0] RegKeepBytes = 3'd5;

  // additive constants, one per step
  localparam logic [31:0] RoundConst [0:63] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // rotate amounts, indexed by {round, step within group of four}
  localparam logic [4:0] RotTable [0:15] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // one item moving down the step pipeline
  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [63:0] point;
  } md5tw_state_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [31:0] chain_a;
    logic [31:0] chain_b;
    logic [31:0] chain_c;
    logic [31:0] chain_d;
    logic [6:0]  step_limit;
    logic [3:0]  keep_bytes;
  } md5tw_cfg_t;

  function automatic logic [4:0] rot_amount(input logic [5:0] idx);
    return RotTable[{idx[5:4], idx[1:0]}];
  endfunction

  // message word index used by a step
  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] x;
    logic [3:0] k;
    x = idx[3:0];
    unique case (idx[5:4])
      2'd0: k = x;
      2'd1: k = 4'(x * 4'd5 + 4'd1);
      2'd2: k = 4'(x * 4'd3 + 4'd5);
      default: k = 4'(x * 4'd7);
    endcase
    return k;
  endfunction

  // word k of the final block built from a walk point
  function automatic logic [31:0] msg_word(input logic [63:0] point, input logic [3:0] k);
    logic [31:0] w;
    priority if (k == 4'd0) w = point[31:0];
    else if (k == 4'd1) w = point[63:32];
    else if (k == 4'd2) w = PadWord;
    else if (k == 4'd14) w = LenWord;
    else w = 32'd0;
    return w;
  endfunction

  // boolean function of each round
  function automatic logic [31:0] round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (rnd)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] x;
    x = {v, v} << n;
    return x[63:32];
  endfunction

endpackage

// ===== hw/rtl/md5tw_cfg.sv =====
module md5tw_cfg
  import md5tw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output md5tw_cfg_t  cfg
);

  logic [31:0] chain_a;
  logic [31:0] chain_b;
  logic [31:0] chain_c;
  logic [31:0] chain_d;
  logic [6:0]  step_count;
  logic [3:0]  keep_bytes;

  // register file, writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_a    <= InitA;
      chain_b    <= InitB;
      chain_c    <= InitC;
      chain_d    <= InitD;
      step_count <= InitStepCount;
      keep_bytes <= InitKeepBytes;
    end else if (wr_en) begin
      unique case (wr_index)
        RegChainA:    chain_a    <= wr_data;
        RegChainB:    chain_b    <= wr_data;
        RegChainC:    chain_c    <= wr_data;
        RegChainD:    chain_d    <= wr_data;
        RegStepCount: step_count <= wr_data[6:0];
        RegKeepBytes: keep_bytes <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // step count saturates at the pipeline depth
  always_comb begin
    cfg.chain_a    = chain_a;
    cfg.chain_b    = chain_b;
    cfg.chain_c    = chain_c;
    cfg.chain_d    = chain_d;
    cfg.step_limit = (step_count > 7'(MaxSteps)) ? 7'(MaxSteps) : step_count;
    cfg.keep_bytes = keep_bytes;
  end

endmodule

// ===== hw/rtl/md5tw_step.sv =====
module md5tw_step
  import md5tw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [5:0]   step_idx,
  input  logic [6:0]   step_limit,
  input  md5tw_state_t in_state,
  output md5tw_state_t out_state
);

  logic        active;
  logic [31:0] f;
  logic [31:0] t;
  logic [31:0] nb;
  md5tw_state_t state_next;

  // one md5 step, skipped past the configured step count
  always_comb begin
    active = {1'b0, step_idx} < step_limit;
    f  = round_fn(step_idx[5:4], in_state.b, in_state.c, in_state.d);
    t  = in_state.a + f + RoundConst[step_idx]
         + msg_word(in_state.point, msg_index(step_idx));
    nb = in_state.b + rotl(t, rot_amount(step_idx));
    state_next = in_state;
    if (active) begin
      state_next.a = in_state.d;
      state_next.b = nb;
      state_next.c = in_state.b;
      state_next.d = in_state.c;
    end
  end

  // stage register, valid cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_state.valid <= 1'b0;
    end else begin
      out_state.valid <= in_state.valid;
    end
    out_state.a     <= state_next.a;
    out_state.b     <= state_next.b;
    out_state.c     <= state_next.c;
    out_state.d     <= state_next.d;
    out_state.point <= state_next.point;
  end

endmodule

// ===== hw/rtl/md5tw_finish.sv =====
module md5tw_finish
  import md5tw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  md5tw_cfg_t   cfg,
  input  md5tw_state_t in_state,
  output logic         done,
  output logic [63:0]  digest_value
);

  logic [31:0] sum_a;
  logic [31:0] sum_b;
  logic [63:0] mask;

  // feed-forward and byte mask
  always_comb begin
    sum_a = in_state.a + cfg.chain_a;
    sum_b = in_state.b + cfg.chain_b;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < cfg.keep_bytes) ? 8'hFF : 8'h00;
    end
  end

  // result register, strobe cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_state.valid;
    end
    digest_value <= {sum_b, sum_a} & mask;
  end

endmodule

// ===== hw/rtl/md5_truncated_walk_step.sv =====
// Hashes one 64-bit walk point per clock: the point becomes the final block
// of a 72-byte md5 message, which runs through 64 step stages on the loaded
// chaining value, then a feed-forward stage that adds the chaining value and
// masks the result to the configured number of leading bytes. A new item is
// taken in every cycle (busy stays low). The 64 step stages and the
// feed-forward stage each add one register; done and digest_value are driven
// by the feed-forward register. Steps beyond step_count pass the state
// through unchanged, so latency does not depend on step_count. There is no
// result back-pressure: the done strobe lasts one cycle and the value must be
// taken then. Write configuration only while the pipeline is empty.
module md5_truncated_walk_step
  import md5tw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] point,
  output logic        done,
  output logic [63:0] digest_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  md5tw_cfg_t   cfg;
  md5tw_state_t pipe [0:StageCount];

  // handshakes: the pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  md5tw_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline entry from the start transfer
  always_comb begin
    pipe[0].valid = start && !busy;
    pipe[0].a     = cfg.chain_a;
    pipe[0].b     = cfg.chain_b;
    pipe[0].c     = cfg.chain_c;
    pipe[0].d     = cfg.chain_d;
    pipe[0].point = point;
  end

  // one stage per md5 step
  for (genvar g = 0; g < StageCount; g++) begin : g_step
    md5tw_step u_step (
      .clk        (clk),
      .rst        (rst),
      .step_idx   (6'(g)),
      .step_limit (cfg.step_limit),
      .in_state   (pipe[g]),
      .out_state  (pipe[g+1])
    );
  end

  md5tw_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_state     (pipe[StageCount]),
    .done         (done),
    .digest_value (digest_value)
  );

  // accepted start enters the first stage
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> pipe[1].valid)
    else $error("accepted start did not reach the first stage");

  // last stage feeds the done strobe
  a_done_follow: assert property (@(posedge clk) disable iff (rst)
    pipe[StageCount].valid |=> done)
    else $error("result lost at the feed-forward stage");

  a_no_spurious: assert property (@(posedge clk)
    !pipe[StageCount].valid |=> !done)
    else $error("done without an item leaving the last stage");

  // single-byte digest keeps only the low byte
  a_mask: assert property (@(posedge clk) disable iff (rst)
    (done && cfg.keep_bytes == 4'd1) |-> (digest_value[63:8] == 56'd0))
    else $error("digest mask leaked upper bytes");

endmodule
